// ===== design/dfe_pkg.sv =====
`default_nettype none
package dfe_pkg;

  localparam int unsigned MaxPatternBytes = 8;
  localparam int unsigned WinBits = 8 * MaxPatternBytes;
  localparam int unsigned LenBits = $clog2(MaxPatternBytes + 1);
  localparam int unsigned SelBits = (MaxPatternBytes > 1) ? $clog2(MaxPatternBytes) : 1;

  localparam logic [7:0] QuoteChar = 8'h22;
  localparam logic [7:0] BackslashChar = 8'h5C;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_NOT_FOUND = 2'd2,
    KIND_EMPTY     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_START_PATTERN = 2'd0,
    REG_START_LENGTH  = 2'd1,
    REG_END_PATTERN   = 2'd2,
    REG_END_LENGTH    = 2'd3
  } reg_idx_e;

  function automatic logic [LenBits-1:0] clamp_len(logic [3:0] len);
    logic [LenBits-1:0] res;
    if (32'(len) > MaxPatternBytes) begin
      res = LenBits'(MaxPatternBytes);
    end else begin
      res = LenBits'(len);
    end
    return res;
  endfunction

  // oldest window byte lines up with pattern byte 0
  function automatic logic window_match(logic [WinBits-1:0] pat, logic [WinBits-1:0] win,
                                        logic [LenBits-1:0] len);
    logic ok;
    logic [SelBits-1:0] sel;
    ok = 1'b1;
    for (int i = 0; i < MaxPatternBytes; i++) begin
      sel = SelBits'(32'(len) - 32'd1 - 32'(i));
      if (32'(i) < 32'(len)) begin
        if (pat[8*i +: 8] != win[8*sel +: 8]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

// ===== design/delimited_field_extractor.sv =====
`default_nettype none
// channel   direction  signals                       contents
// s_axis    in         tvalid tready tdata tlast     text byte, end of text
// m_axis    out        tvalid tready tdata tuser tlast  field byte, kind, last
// cfg       in         valid ready index data        register writes, always ready
//
// one text byte per cycle unless m_axis stalls; an accepted item sits in the input register,
// then its output, if any, goes to the result register (8-byte window match logic between).
// async active-low reset clears phase, window and both stage valids.
// a stall on m_axis holds the result register and, behind it, the input register.
module delimited_field_extractor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  wire logic        s_axis_tlast_i,   // end_of_text
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [7:0]  m_axis_tdata_o,   // [7:0] field_byte
  output      logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output      logic        m_axis_tlast_o,   // last
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  logic [dfe_pkg::WinBits-1:0] start_pat_q, end_pat_q;
  logic [3:0] start_len_q, end_len_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eot_q;

  logic                        coll_q, coll_d;
  logic [dfe_pkg::WinBits-1:0] win_q, win_d;
  logic [dfe_pkg::LenBits-1:0] cnt_q, cnt_d;

  logic        out_valid_q;
  logic [7:0]  out_byte_q, out_byte_d;
  logic [1:0]  out_kind_q, out_kind_d;
  logic        produce;

  logic advance;
  logic [dfe_pkg::LenBits-1:0] slen, elen, cnt_inc;
  logic [dfe_pkg::SelBits-1:0] old_sel;
  logic empty_pat, hit;

  assign cfg_ready_o = 1'b1;
  assign advance = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pat_q <= '0;
      start_len_q <= '0;
      end_pat_q   <= '0;
      end_len_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dfe_pkg::REG_START_PATTERN: start_pat_q <= cfg_data_i;
        dfe_pkg::REG_START_LENGTH:  start_len_q <= cfg_data_i[3:0];
        dfe_pkg::REG_END_PATTERN:   end_pat_q   <= cfg_data_i;
        dfe_pkg::REG_END_LENGTH:    end_len_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_eot_q  <= s_axis_tlast_i;
    end
  end

  always_comb begin
    slen = dfe_pkg::clamp_len(start_len_q);
    elen = dfe_pkg::clamp_len(end_len_q);
    empty_pat = (slen == '0) || (elen == '0);
    coll_d = coll_q;
    win_d = win_q;
    cnt_d = cnt_q;
    produce = 1'b0;
    out_byte_d = '0;
    out_kind_d = dfe_pkg::KIND_BYTE;
    hit = 1'b0;
    old_sel = dfe_pkg::SelBits'(32'(elen) - 32'd1);
    cnt_inc = (32'(cnt_q) < dfe_pkg::MaxPatternBytes) ? cnt_q + 1'b1 : cnt_q;
    if (in_eot_q) begin
      coll_d = 1'b0;
      win_d = '0;
      cnt_d = '0;
      produce = 1'b1;
      out_kind_d = empty_pat ? dfe_pkg::KIND_EMPTY : dfe_pkg::KIND_NOT_FOUND;
    end else if (empty_pat) begin
      coll_d = 1'b0;
      win_d = '0;
      cnt_d = '0;
    end else begin
      win_d = {win_q[dfe_pkg::WinBits-9:0], in_byte_q};
      cnt_d = cnt_inc;
      if (!coll_q) begin
        if (cnt_inc >= slen && dfe_pkg::window_match(start_pat_q, win_d, slen)) begin
          coll_d = 1'b1;
          cnt_d = '0;
        end
      end else begin
        hit = (cnt_inc >= elen) && dfe_pkg::window_match(end_pat_q, win_d, elen);
        // escaped quote stays inside the field
        if (elen == dfe_pkg::LenBits'(1) && end_pat_q[7:0] == dfe_pkg::QuoteChar &&
            win_d[15:8] == dfe_pkg::BackslashChar) begin
          hit = 1'b0;
        end
        if (hit) begin
          coll_d = 1'b0;
          cnt_d = '0;
          produce = 1'b1;
          out_kind_d = dfe_pkg::KIND_DONE;
        end else if (cnt_inc >= elen) begin
          produce = 1'b1;
          out_byte_d = win_d[8*old_sel +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coll_q <= 1'b0;
      win_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && produce;
      if (in_valid_q) begin
        coll_q <= coll_d;
        win_q <= win_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && produce) begin
      out_byte_q <= out_byte_d;
      out_kind_q <= out_kind_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = out_byte_q;
  assign m_axis_tuser_o = out_kind_q;
  assign m_axis_tlast_o = (out_kind_q != dfe_pkg::KIND_BYTE);

endmodule
`default_nettype wire
